[design/prefix_free_code_check_defines.svh]
// assertion macros shared by the prefix-free check rtl
// no dependencies; included by the files that carry assertions
`ifndef PREFIX_FREE_CODE_CHECK_DEFINES_SVH
`define PREFIX_FREE_CODE_CHECK_DEFINES_SVH

`ifndef SYNTHESIS
// clocked check, off while reset is asserted
`define PFCC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked check that also holds during reset
`define PFCC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PFCC_ASSERT(lbl, clk, rst_n, prop, msg)
`define PFCC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

[design/pfcc_pkg.sv]
// shared types, sizes and helpers of the prefix-free check
// no dependencies; used by pfcc_ctrl and prefix_free_code_check
package pfcc_pkg;

    localparam int MAX_ENTRIES = 8;
    localparam int MAX_CHARS   = 8;

    localparam int IDX_W     = $clog2(MAX_ENTRIES);
    localparam int CNT_W     = $clog2(MAX_ENTRIES + 1);
    localparam int CHARS_W   = 64;
    localparam int LEN_W     = 4;
    localparam int OUT_IDX_W = 3;

    typedef struct packed {
        logic [LEN_W-1:0]   len;
        logic [CHARS_W-1:0] chars;
    } entry_t;

    typedef struct packed {
        logic                 found;
        logic [OUT_IDX_W-1:0] shorter;
        logic [OUT_IDX_W-1:0] longer;
        logic                 ovf;
    } result_t;

    localparam int ENTRY_W = $bits(entry_t);

    function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] len);
        return (len > LEN_W'(MAX_CHARS)) ? LEN_W'(MAX_CHARS) : len;
    endfunction

    // one byte of ones for every character inside the length
    function automatic logic [CHARS_W-1:0] byte_mask(input logic [LEN_W-1:0] len);
        logic [CHARS_W-1:0] m;
        m = '0;
        for (int b = 0; b < CHARS_W / 8; b++)
        begin
            if (LEN_W'(b) < len)
            begin
                m[8*b +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage

[design/prefix_free_code_check.sv]
// top level of the prefix-free check: entry store, search sequencer, result register
// depends on pfcc_pkg, pfcc_ram and pfcc_ctrl
//
// channel  direction  handshake            payload
// in       in         in_valid / in_stall  entry_chars, entry_length, last_entry
// out      out        out_valid/out_stall  prefix_found, shorter_index, longer_index, overflow
//
// a word that is not last is stored and the next can follow right after
// the last word starts a sweep over the entry ram through its single read port: each outer
// entry is read and latched, then compared with each later entry until a pair is found;
// with fewer than two entries there is no sweep; the result then waits for the output register
// reset clears counts and flags; the entry ram is not cleared, only written slots are compared
// the result waits in an output register while out_stall is high; loading goes on meanwhile
module prefix_free_code_check (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [pfcc_pkg::CHARS_W-1:0]        entry_chars,
    input  logic [pfcc_pkg::LEN_W-1:0]          entry_length,
    input  logic                                last_entry,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                prefix_found,
    output logic [pfcc_pkg::OUT_IDX_W-1:0]      shorter_index,
    output logic [pfcc_pkg::OUT_IDX_W-1:0]      longer_index,
    output logic                                overflow
);

    logic                         out_valid_reg, out_valid_next;
    pfcc_pkg::result_t            res_reg;
    pfcc_pkg::result_t            res;
    logic                         res_valid;
    logic                         out_free;
    logic                         load;

    logic                         mem_we;
    logic [pfcc_pkg::IDX_W-1:0]   mem_waddr;
    pfcc_pkg::entry_t             mem_wdata;
    logic [pfcc_pkg::IDX_W-1:0]   mem_raddr;
    pfcc_pkg::entry_t             mem_rdata;

    pfcc_ram #(
        .WIDTH (pfcc_pkg::ENTRY_W),
        .DEPTH (pfcc_pkg::MAX_ENTRIES)
    ) u_entry_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    pfcc_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .entry_chars  (entry_chars),
        .entry_length (entry_length),
        .last_entry   (last_entry),
        .out_free     (out_free),
        .res_valid    (res_valid),
        .res          (res),
        .mem_we       (mem_we),
        .mem_waddr    (mem_waddr),
        .mem_wdata    (mem_wdata),
        .mem_raddr    (mem_raddr),
        .mem_rdata    (mem_rdata)
    );

    // output register is free when empty or being taken this cycle
    assign out_free = !out_valid_reg || !out_stall;
    assign load     = res_valid && out_free;

    always_comb
    begin
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign prefix_found  = res_reg.found;
    assign shorter_index = res_reg.shorter;
    assign longer_index  = res_reg.longer;
    assign overflow      = res_reg.ovf;

endmodule

[design/pfcc_ram.sv]
// generic single-write, single-read ram with registered read data
// no dependencies
module pfcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[design/pfcc_ctrl.sv]
// load and pair-search sequencer of the prefix-free check
// depends on pfcc_pkg and prefix_free_code_check_defines.svh; drives one pfcc_ram
`include "prefix_free_code_check_defines.svh"

module pfcc_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [pfcc_pkg::CHARS_W-1:0]  entry_chars,
    input  logic [pfcc_pkg::LEN_W-1:0]    entry_length,
    input  logic                          last_entry,
    input  logic                          out_free,
    output logic                          res_valid,
    output pfcc_pkg::result_t             res,
    output logic                          mem_we,
    output logic [pfcc_pkg::IDX_W-1:0]    mem_waddr,
    output pfcc_pkg::entry_t              mem_wdata,
    output logic [pfcc_pkg::IDX_W-1:0]    mem_raddr,
    input  pfcc_pkg::entry_t              mem_rdata
);

    localparam logic [2:0] ST_LOAD  = 3'd0;
    localparam logic [2:0] ST_RDI   = 3'd1;
    localparam logic [2:0] ST_LATCH = 3'd2;
    localparam logic [2:0] ST_CMP   = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]                   state_reg, state_next;
    logic [pfcc_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic                         ovf_reg, ovf_next;
    logic [pfcc_pkg::IDX_W-1:0]   i_reg, i_next;
    logic [pfcc_pkg::IDX_W-1:0]   j_reg, j_next;
    logic                         found_reg, found_next;
    logic [pfcc_pkg::IDX_W-1:0]   si_reg, si_next;
    logic [pfcc_pkg::IDX_W-1:0]   li_reg, li_next;
    pfcc_pkg::entry_t             outer_reg, outer_next;

    logic                         accept;
    logic                         room;
    logic [pfcc_pkg::LEN_W-1:0]   len_sat;
    logic [pfcc_pkg::CNT_W-1:0]   cnt_after;
    logic                         match;
    logic [pfcc_pkg::IDX_W-1:0]   i_inc;
    logic [pfcc_pkg::IDX_W-1:0]   j_inc;

    assign accept    = in_valid && (state_reg == ST_LOAD);
    assign in_stall  = (state_reg != ST_LOAD);
    assign room      = cnt_reg < pfcc_pkg::CNT_W'(pfcc_pkg::MAX_ENTRIES);
    assign len_sat   = pfcc_pkg::sat_len(entry_length);
    assign cnt_after = room ? cnt_reg + pfcc_pkg::CNT_W'(1) : cnt_reg;
    assign i_inc     = i_reg + pfcc_pkg::IDX_W'(1);
    assign j_inc     = j_reg + pfcc_pkg::IDX_W'(1);

    // stored words are already masked to their length
    assign match = (outer_reg.len <= mem_rdata.len) &&
                   (((outer_reg.chars ^ mem_rdata.chars) &
                     pfcc_pkg::byte_mask(outer_reg.len)) == '0);

    assign mem_we          = accept && room;
    assign mem_waddr       = cnt_reg[pfcc_pkg::IDX_W-1:0];
    assign mem_wdata.len   = len_sat;
    assign mem_wdata.chars = entry_chars & pfcc_pkg::byte_mask(len_sat);

    assign res_valid   = (state_reg == ST_DONE);
    assign res.found   = found_reg;
    assign res.shorter = pfcc_pkg::OUT_IDX_W'(si_reg);
    assign res.longer  = pfcc_pkg::OUT_IDX_W'(li_reg);
    assign res.ovf     = ovf_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ovf_next   = ovf_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        found_next = found_reg;
        si_next    = si_reg;
        li_next    = li_reg;
        outer_next = outer_reg;
        mem_raddr  = i_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    cnt_next = cnt_after;
                    if (!room)
                    begin
                        ovf_next = 1'b1;
                    end
                    if (last_entry)
                    begin
                        found_next = 1'b0;
                        si_next    = '0;
                        li_next    = '0;
                        i_next     = '0;
                        state_next = (cnt_after < pfcc_pkg::CNT_W'(2)) ? ST_DONE : ST_RDI;
                    end
                end
            end
            ST_RDI:
            begin
                mem_raddr  = i_reg;
                state_next = ST_LATCH;
            end
            ST_LATCH:
            begin
                // outer entry arrives, start the inner sweep at the next slot
                outer_next = mem_rdata;
                mem_raddr  = i_inc;
                j_next     = i_inc;
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (match)
                begin
                    found_next = 1'b1;
                    si_next    = i_reg;
                    li_next    = j_reg;
                    state_next = ST_DONE;
                end
                else if (pfcc_pkg::CNT_W'(j_reg) + pfcc_pkg::CNT_W'(1) < cnt_reg)
                begin
                    mem_raddr = j_inc;
                    j_next    = j_inc;
                end
                else if (pfcc_pkg::CNT_W'(i_reg) + pfcc_pkg::CNT_W'(2) < cnt_reg)
                begin
                    mem_raddr  = i_inc;
                    i_next     = i_inc;
                    state_next = ST_LATCH;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cnt_next   = '0;
                    ovf_next   = 1'b0;
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            cnt_reg   <= '0;
            ovf_reg   <= 1'b0;
            i_reg     <= '0;
            j_reg     <= '0;
            found_reg <= 1'b0;
            si_reg    <= '0;
            li_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ovf_reg   <= ovf_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            found_reg <= found_next;
            si_reg    <= si_next;
            li_reg    <= li_next;
        end
    end

    always_ff @(posedge clk)
    begin
        outer_reg <= outer_next;
    end

    `PFCC_ASSERT(a_cnt_range, clk, rst_n, cnt_reg <= pfcc_pkg::CNT_W'(pfcc_pkg::MAX_ENTRIES), "entry count past capacity")
    `PFCC_ASSERT(a_ovf_full, clk, rst_n, ovf_reg |-> (cnt_reg == pfcc_pkg::CNT_W'(pfcc_pkg::MAX_ENTRIES)), "overflow with room left")
    `PFCC_ASSERT(a_pair_order, clk, rst_n, (state_reg == ST_CMP) |-> (j_reg > i_reg), "inner slot not after outer slot")
    `PFCC_ASSERT(a_pair_held, clk, rst_n, (state_reg == ST_CMP) |-> (pfcc_pkg::CNT_W'(j_reg) < cnt_reg), "inner slot beyond stored entries")
    `PFCC_ASSERT(a_list_clear, clk, rst_n, (res_valid && out_free) |=> ((cnt_reg == '0) && !ovf_reg), "list not cleared after result")

endmodule

[dv/prefix_free_code_check_test.sv]
`timescale 1ns / 1ps
// self-checking bench for prefix_free_code_check: lists of entries in, one verdict per list out
// depends on pfcc_pkg and the prefix_free_code_check rtl
module prefix_free_code_check_test;

    localparam int HALF_PERIOD    = 6;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int HOLD_CYCLES    = 150;
    localparam int SETTLE_CYCLES  = 40;
    localparam int MAX_REPORTS    = 10;
    localparam int MAX_ENTRIES    = pfcc_pkg::MAX_ENTRIES;
    localparam int MAX_CHARS      = pfcc_pkg::MAX_CHARS;
    localparam logic [7:0] LETTERS [4] = '{8'h00, 8'h61, 8'h62, 8'hFF};

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [pfcc_pkg::CHARS_W-1:0] entry_chars = '0;
    logic [pfcc_pkg::LEN_W-1:0] entry_length = '0;
    logic last_entry = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic prefix_found;
    logic [pfcc_pkg::OUT_IDX_W-1:0] shorter_index;
    logic [pfcc_pkg::OUT_IDX_W-1:0] longer_index;
    logic overflow;

    // copy of the entry list the block is building
    logic [pfcc_pkg::CHARS_W-1:0] held_chars [MAX_ENTRIES];
    logic [pfcc_pkg::LEN_W-1:0] held_len [MAX_ENTRIES];
    int held_count = 0;
    bit held_dropped = 1'b0;
    pfcc_pkg::result_t pending_verdicts [$];

    bit in_gaps_on = 1'b1;
    bit out_gaps_on = 1'b1;
    bit hold_request = 1'b0;
    int items_sent = 0;
    int entries_seen = 0;
    int lists_done = 0;
    int pairs_found = 0;
    int lists_overflowed = 0;
    int verdicts_checked = 0;
    int failures = 0;
    int quiet_cycles = 0;

    prefix_free_code_check dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .entry_chars   (entry_chars),
        .entry_length  (entry_length),
        .last_entry    (last_entry),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .prefix_found  (prefix_found),
        .shorter_index (shorter_index),
        .longer_index  (longer_index),
        .overflow      (overflow)
    );

    always #(HALF_PERIOD) clk = ~clk;

    function automatic logic [pfcc_pkg::CHARS_W-1:0] keep_bytes(
        input logic [pfcc_pkg::LEN_W-1:0] n);
        if (n >= 4'd8)
            return '1;
        return (64'd1 << (8 * n)) - 64'd1;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic void absorb_entry(
        input logic [pfcc_pkg::CHARS_W-1:0] chars,
        input logic [pfcc_pkg::LEN_W-1:0] len_in,
        input logic is_last);
        logic [pfcc_pkg::LEN_W-1:0] len;
        logic [pfcc_pkg::CHARS_W-1:0] m;
        pfcc_pkg::result_t verdict;
        len = (len_in > pfcc_pkg::LEN_W'(MAX_CHARS)) ? pfcc_pkg::LEN_W'(MAX_CHARS) : len_in;
        entries_seen++;
        if (held_count < MAX_ENTRIES)
        begin
            held_chars[held_count] = chars & keep_bytes(len);
            held_len[held_count] = len;
            held_count++;
        end
        else
        begin
            held_dropped = 1'b1;
        end
        if (!is_last)
            return;
        verdict = '0;
        // first pair in list order: earlier word outer, later word inner
        for (int i = 0; i + 1 < held_count && !verdict.found; i++)
        begin
            m = keep_bytes(held_len[i]);
            for (int j = i + 1; j < held_count && !verdict.found; j++)
            begin
                if (held_len[i] <= held_len[j] && ((held_chars[i] ^ held_chars[j]) & m) == '0)
                begin
                    verdict.found = 1'b1;
                    verdict.shorter = pfcc_pkg::OUT_IDX_W'(i);
                    verdict.longer = pfcc_pkg::OUT_IDX_W'(j);
                end
            end
        end
        verdict.ovf = held_dropped;
        pending_verdicts.push_back(verdict);
        lists_done++;
        pairs_found += verdict.found;
        lists_overflowed += verdict.ovf;
        held_count = 0;
        held_dropped = 1'b0;
    endfunction

    task automatic log_failure(input string what, input pfcc_pkg::result_t want,
        input pfcc_pkg::result_t got);
        failures++;
        if (failures <= MAX_REPORTS)
            $display("%0t %s: expected found=%0d shorter=%0d longer=%0d overflow=%0d,",
                $realtime, what, want.found, want.shorter, want.longer, want.ovf,
                " got found=%0d shorter=%0d longer=%0d overflow=%0d",
                got.found, got.shorter, got.longer, got.ovf);
    endtask

    // input side: every accepted word goes into the predictor
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            absorb_entry(entry_chars, entry_length, last_entry);
    end

    // output side: every accepted verdict against the oldest prediction
    always @(posedge clk)
    begin
        pfcc_pkg::result_t want;
        pfcc_pkg::result_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.found = prefix_found;
            got.shorter = shorter_index;
            got.longer = longer_index;
            got.ovf = overflow;
            verdicts_checked++;
            if (pending_verdicts.size() == 0)
            begin
                log_failure("verdict with nothing pending", '0, got);
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (got.found !== want.found || got.shorter !== want.shorter ||
                    got.longer !== want.longer || got.ovf !== want.ovf)
                    log_failure("verdict mismatch", want, got);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no word moved for %0d cycles, %0d verdicts outstanding",
                quiet_cycles, pending_verdicts.size());
            $display("Regression FAIL");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // receiver: random stalls, plus one long hold when asked
    initial
    begin
        int span;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                out_stall <= 1'b1;
                for (span = 0; span < HOLD_CYCLES; span++)
                    @(posedge clk);
                hold_request = 1'b0;
                out_stall <= 1'b0;
            end
            else if (out_gaps_on && $urandom_range(0, 99) < 35)
            begin
                out_stall <= 1'b1;
                repeat (1 + pick_gap()) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic send_entry(input logic [pfcc_pkg::CHARS_W-1:0] chars,
        input logic [pfcc_pkg::LEN_W-1:0] len, input logic is_last);
        int gap;
        in_valid <= 1'b1;
        entry_chars <= chars;
        entry_length <= len;
        last_entry <= is_last;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
        gap = in_gaps_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        // let the predictor take the word accepted at this edge first
        @(posedge clk);
        while (pending_verdicts.size() != 0)
            @(posedge clk);
    endtask

    // a list of random words, many of them built from earlier ones in the same list
    task automatic send_random_list();
        logic [pfcc_pkg::CHARS_W-1:0] sent_chars [16];
        logic [pfcc_pkg::LEN_W-1:0] sent_len [16];
        logic [pfcc_pkg::CHARS_W-1:0] chars;
        logic [pfcc_pkg::LEN_W-1:0] len;
        int n;
        int r;
        int src;
        int pick;
        r = $urandom_range(0, 99);
        if (r < 5)
            n = 1;
        else if (r < 88)
            n = $urandom_range(2, MAX_ENTRIES);
        else
            n = $urandom_range(MAX_ENTRIES + 1, MAX_ENTRIES + 4);
        for (int k = 0; k < n; k++)
        begin
            chars = {$urandom, $urandom};
            pick = $urandom_range(0, 9);
            if (k > 0 && pick < 4)
            begin
                src = $urandom_range(0, k - 1);
                chars = (sent_chars[src] & keep_bytes(sent_len[src])) |
                        (chars & ~keep_bytes(sent_len[src]));
                len = pfcc_pkg::LEN_W'($urandom_range(0, MAX_CHARS));
                if ($urandom_range(0, 3) == 0)
                begin
                    r = $urandom_range(0, 23);
                    chars[r] = ~chars[r];
                end
            end
            else if (pick < 8)
            begin
                len = pfcc_pkg::LEN_W'($urandom_range(0, 4));
                for (int b = 0; b < len; b++)
                    chars[8*b +: 8] = LETTERS[$urandom_range(0, 3)];
            end
            else if (pick == 8)
            begin
                len = pfcc_pkg::LEN_W'($urandom_range(0, 15));
            end
            else
            begin
                len = '0;
            end
            sent_chars[k] = chars;
            sent_len[k] = (len > pfcc_pkg::LEN_W'(MAX_CHARS)) ? pfcc_pkg::LEN_W'(MAX_CHARS) : len;
            send_entry(chars, len, k == n - 1);
        end
    endtask

    task automatic test_directed();
        // empty word is a prefix of anything after it
        send_entry(64'hDEAD_BEEF_0000_0000, 4'd0, 1'b0);
        send_entry(64'h6261, 4'd2, 1'b1);
        // equal words, junk above the length
        send_entry(64'h636261, 4'd3, 1'b0);
        send_entry(64'hFF00_0000_0063_6261, 4'd3, 1'b1);
        // later word shorter, and no pair at all
        send_entry(64'h636261, 4'd3, 1'b0);
        send_entry(64'h6261, 4'd2, 1'b0);
        send_entry(64'h6361, 4'd2, 1'b1);
        // length above the limit saturates
        send_entry('1, 4'd15, 1'b0);
        send_entry('1, 4'd8, 1'b1);
        // zero byte inside the length is a real character
        send_entry(64'hAB00, 4'd1, 1'b0);
        send_entry(64'h0100, 4'd2, 1'b1);
        // store full: ninth word dropped but still closes the list
        for (int k = 0; k < MAX_ENTRIES; k++)
            send_entry(64'h61 + k, 4'd1, 1'b0);
        send_entry(64'h61, 4'd1, 1'b1);
        // list of a single word
        send_entry('0, 4'd0, 1'b1);
        // first pair in search order is (0, 2), not (1, 3)
        send_entry(64'h6261, 4'd2, 1'b0);
        send_entry(64'h61, 4'd1, 1'b0);
        send_entry(64'h636261, 4'd3, 1'b0);
        send_entry(64'h61, 4'd1, 1'b1);
    endtask

    task automatic test_random_lists(input int count);
        int stop;
        stop = items_sent + count;
        while (items_sent < stop)
            send_random_list();
    endtask

    task automatic test_no_idle(input int count);
        in_gaps_on = 1'b0;
        out_gaps_on = 1'b0;
        test_random_lists(count);
        in_gaps_on = 1'b1;
        out_gaps_on = 1'b1;
    endtask

    // receiver holds off while the sender keeps pushing lists back to back
    task automatic test_backpressure();
        hold_request = 1'b1;
        in_gaps_on = 1'b0;
        repeat (12) send_random_list();
        in_gaps_on = 1'b1;
    endtask

    task automatic test_drain_pause();
        repeat (10)
        begin
            send_random_list();
            wait_for_results();
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_lists(1300);
        test_no_idle(150);
        test_backpressure();
        test_drain_pause();
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("sent %0d entries in %0d lists; %0d lists held a prefix pair, %0d overflowed",
            entries_seen, lists_done, pairs_found, lists_overflowed);
        $display("checked %0d verdicts, %0d failures", verdicts_checked, failures);
        if (failures == 0 && pending_verdicts.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
